// ----- hw/rtl/plbu_pkg.sv -----
`default_nettype none
package plbu_pkg;

  typedef struct packed {
    logic        side_is_ask;
    logic [31:0] price;
    logic [31:0] size;
  } plbu_in_t;

  typedef struct packed {
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [31:0] bid_size;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [31:0] ask_size;
  } plbu_out_t;

  // result of the shared compare / add unit
  typedef struct packed {
    logic        ahead;   // stored level ranks strictly ahead of the update price
    logic        equal;
    logic [31:0] sum;     // saturated size sum
  } plbu_alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_INS_START,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS_WR,
    ST_DONE
  } plbu_state_e;

  localparam logic [31:0] SIZE_MAX = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ----- hw/rtl/plbu_ram.sv -----
`default_nettype none
module plbu_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/plbu_alu.sv -----
`default_nettype none
module plbu_alu import plbu_pkg::*; (
  input  wire logic        ask_i,
  input  wire logic [31:0] lvl_price_i,
  input  wire logic [31:0] lvl_size_i,
  input  wire logic [31:0] upd_price_i,
  input  wire logic [31:0] upd_size_i,
  output      plbu_alu_res_t res_o
);

  logic [32:0] sum_full;

  always_comb begin
    sum_full    = {1'b0, lvl_size_i} + {1'b0, upd_size_i};
    res_o.ahead = ask_i ? (lvl_price_i < upd_price_i) : (lvl_price_i > upd_price_i);
    res_o.equal = (lvl_price_i == upd_price_i);
    res_o.sum   = sum_full[32] ? SIZE_MAX : sum_full[31:0];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/price_level_book_update_core.sv -----
// Price-level book: sorted bid (descending) and ask (ascending) level tables.
//
// Input channel in_valid_i / in_ready_o / in_data_i carries one update word:
// side, price in ticks, size in lots. Size zero removes the level; any other
// size adds to it (creating it if absent), saturating at all ones. A side
// that grows past LEVELS drops its worst level.
// Output channel out_valid_o / out_ready_i / out_data_o carries one word per
// update: best bid and best ask with valid flags (price/size 0 when empty).
//
// An update scans S levels that rank ahead of the update price's slot and then
// moves M levels for an insert or delete (S + M <= LEVELS). Both tables live
// in one single-port-write RAM with registered read, so each scan compare and
// each level move is a read state (SCAN_RD / SHIFT_RD) followed by a compare
// or write state (SCAN_CMP / SHIFT_WR).
// in_ready_o is high only while idle. A finished word sits in the output
// register; the next update is accepted and worked on meanwhile, and only
// its final hand-off waits if the receiver still stalls.
// Reset clears both level counts and the output valid; RAM contents are
// never cleared, since only entries below the count are used.
`default_nettype none
module price_level_book_update_core import plbu_pkg::*; #(
  parameter int LEVELS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_ready_o,
  input  wire plbu_in_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      plbu_out_t out_data_o
);

  // index width for a level slot, count width to hold 0..LEVELS
  localparam int IW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW    = $clog2(LEVELS + 1);
  localparam int Depth = 2 * (1 << IW);
  localparam logic [CW-1:0] LvlC = CW'(LEVELS);
  localparam logic [CW-1:0] OneC = CW'(1);

  plbu_state_e state_q, state_d;

  logic          side_q, side_d;
  logic [31:0]   price_q, price_d;
  logic [31:0]   size_q, size_d;
  logic [CW-1:0] n_q, n_d;          // level count of the side being updated
  logic [CW-1:0] i_q, i_d;          // scan position / target slot
  logic [CW-1:0] k_q, k_d;          // move position
  logic          del_q, del_d;      // moves run toward the top (delete)

  logic [CW-1:0] bid_cnt_q, ask_cnt_q;
  logic [31:0]   bid_best_price_q, bid_best_size_q;
  logic [31:0]   ask_best_price_q, ask_best_size_q;

  logic      out_valid_q;
  plbu_out_t out_q, out_d;
  logic      out_load;

  logic          cnt_we;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] k_start;
  logic [CW-1:0] rd_idx;

  logic          ram_we;
  logic [CW-1:0] wr_idx;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  plbu_alu_res_t alu_res;

  // shared compare / saturating add on the level just read
  plbu_alu u_alu (
    .ask_i       (side_q),
    .lvl_price_i (ram_rdata[63:32]),
    .lvl_size_i  (ram_rdata[31:0]),
    .upd_price_i (price_q),
    .upd_size_i  (size_q),
    .res_o       (alu_res)
  );

  // both tables: side bit selects the upper half
  plbu_ram #(
    .Width (64),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({side_q, wr_idx[IW-1:0]}),
    .wdata_i (ram_wdata),
    .raddr_i ({side_q, rd_idx[IW-1:0]}),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // output word from the live best registers
  always_comb begin
    out_d.bid_valid = (bid_cnt_q != '0);
    out_d.bid_price = out_d.bid_valid ? bid_best_price_q : 32'd0;
    out_d.bid_size  = out_d.bid_valid ? bid_best_size_q  : 32'd0;
    out_d.ask_valid = (ask_cnt_q != '0);
    out_d.ask_price = out_d.ask_valid ? ask_best_price_q : 32'd0;
    out_d.ask_size  = out_d.ask_valid ? ask_best_size_q  : 32'd0;
  end

  assign k_start = (n_q == LvlC) ? (LvlC - OneC) : n_q;

  always_comb begin
    state_d   = state_q;
    side_d    = side_q;
    price_d   = price_q;
    size_d    = size_q;
    n_d       = n_q;
    i_d       = i_q;
    k_d       = k_q;
    del_d     = del_q;
    cnt_we    = 1'b0;
    cnt_new   = n_q;
    ram_we    = 1'b0;
    wr_idx    = i_q;
    ram_wdata = {price_q, size_q};
    rd_idx    = i_q;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          side_d  = in_data_i.side_is_ask;
          price_d = in_data_i.price;
          size_d  = in_data_i.size;
          n_d     = in_data_i.side_is_ask ? ask_cnt_q : bid_cnt_q;
          i_d     = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        rd_idx = i_q;
        if (i_q == n_q) begin
          state_d = ST_INS_START;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (alu_res.ahead) begin
          i_d     = i_q + OneC;
          state_d = ST_SCAN_RD;
        end else if (alu_res.equal) begin
          if (size_q == 32'd0) begin
            del_d = 1'b1;
            k_d   = i_q;
            if ({1'b0, i_q} + {1'b0, OneC} < {1'b0, n_q}) begin
              state_d = ST_SHIFT_RD;
            end else begin
              cnt_we  = 1'b1;
              cnt_new = n_q - OneC;
              state_d = ST_DONE;
            end
          end else begin
            ram_we    = 1'b1;
            wr_idx    = i_q;
            ram_wdata = {price_q, alu_res.sum};
            state_d   = ST_DONE;
          end
        end else begin
          state_d = ST_INS_START;
        end
      end
      ST_INS_START: begin
        del_d = 1'b0;
        if (size_q == 32'd0 || i_q == LvlC) begin
          // absent level removed, or new level falls off the end
          state_d = ST_DONE;
        end else if (k_start > i_q) begin
          k_d     = k_start;
          state_d = ST_SHIFT_RD;
        end else begin
          state_d = ST_INS_WR;
        end
      end
      ST_SHIFT_RD: begin
        rd_idx  = del_q ? (k_q + OneC) : (k_q - OneC);
        state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        wr_idx    = k_q;
        ram_wdata = ram_rdata;
        if (del_q) begin
          if ({1'b0, k_q} + {1'b0, OneC} + {1'b0, OneC} < {1'b0, n_q}) begin
            k_d     = k_q + OneC;
            state_d = ST_SHIFT_RD;
          end else begin
            cnt_we  = 1'b1;
            cnt_new = n_q - OneC;
            state_d = ST_DONE;
          end
        end else begin
          k_d = k_q - OneC;
          if ((k_q - OneC) > i_q) begin
            state_d = ST_SHIFT_RD;
          end else begin
            state_d = ST_INS_WR;
          end
        end
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        wr_idx    = i_q;
        ram_wdata = {price_q, size_q};
        cnt_we    = 1'b1;
        cnt_new   = (n_q == LvlC) ? n_q : (n_q + OneC);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_we) begin
        if (side_q) begin
          ask_cnt_q <= cnt_new;
        end else begin
          bid_cnt_q <= cnt_new;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    side_q  <= side_d;
    price_q <= price_d;
    size_q  <= size_d;
    n_q     <= n_d;
    i_q     <= i_d;
    k_q     <= k_d;
    del_q   <= del_d;
    if (out_load) begin
      out_q <= out_d;
    end
    // shadow of slot 0 of each side
    if (ram_we && wr_idx == '0) begin
      if (side_q) begin
        ask_best_price_q <= ram_wdata[63:32];
        ask_best_size_q  <= ram_wdata[31:0];
      end else begin
        bid_best_price_q <= ram_wdata[63:32];
        bid_best_size_q  <= ram_wdata[31:0];
      end
    end
  end

  // counts never exceed LEVELS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_cnt_q <= LvlC) && (ask_cnt_q <= LvlC))
    else $error("level count above LEVELS");

  // the table is written only while an update is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE && state_q != ST_DONE))
    else $error("table write outside an update");

  // the scan never runs past the stored levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_RD || state_q == ST_SCAN_CMP) |-> (i_q <= n_q))
    else $error("scan index beyond count");

  // a word held while the receiver stalls is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> !$past(out_load))
    else $error("output word overwritten");

endmodule
`default_nettype wire
